// File: hw/rtl/b2b_pkg.sv
// BLAKE2b engine package: constants, sigma table, IV and helpers.
// No dependencies.
`default_nettype none
package b2b_pkg;
    localparam int WordW   = 64;
    localparam int BlkWords = 16;
    localparam int Rounds  = 12;
    localparam logic [63:0] ParamXor = 64'h0000_0000_0101_0000;

    typedef logic [63:0] t_word;

    function automatic t_word iv(input logic [2:0] i);
        case (i)
            3'd0: iv = 64'h6a09e667f3bcc908;
            3'd1: iv = 64'hbb67ae8584caa73b;
            3'd2: iv = 64'h3c6ef372fe94f82b;
            3'd3: iv = 64'ha54ff53a5f1d36f1;
            3'd4: iv = 64'h510e527fade682d1;
            3'd5: iv = 64'h9b05688c2b3e6c1f;
            3'd6: iv = 64'h1f83d9abfb41bd6b;
            default: iv = 64'h5be0cd19137e2179;
        endcase
    endfunction

    // sigma[r][k], r in 0..9, k in 0..15
    function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] k);
        logic [63:0] row;
        case (r)
            4'd0: row = 64'hfedcba9876543210;
            4'd1: row = 64'h357b20c16df984ae;
            4'd2: row = 64'h491763eadf250c8b;
            4'd3: row = 64'h8f04a562ebcd1397;
            4'd4: row = 64'hd386cb1efa427509;
            4'd5: row = 64'h91ef57d438b0a6c2;
            4'd6: row = 64'hb8293670a4def15c;
            4'd7: row = 64'ha2684f05931ce7bd;
            4'd8: row = 64'h5a417d2c803b9ef6;
            default: row = 64'h0dc3e9bf5167482a;
        endcase
        sigma = row[k*4 +: 4];
    endfunction

    function automatic logic [6:0] clamp_len(input logic [6:0] v);
        if (v == 7'd0) clamp_len = 7'd1;
        else if (v > 7'd64) clamp_len = 7'd64;
        else clamp_len = v;
    endfunction
endpackage
`default_nettype wire

// File: hw/rtl/b2b_if.sv
// Channel interfaces for message and digest words, and the length write channel.
// No dependencies.
`default_nettype none
interface b2b_msg_if;
    logic        valid;
    logic        ready;
    logic [63:0] msg_word;
    logic [3:0]  byte_count;
    logic        last_word;
    modport source (output valid, msg_word, byte_count, last_word, input ready);
    modport sink   (input valid, msg_word, byte_count, last_word, output ready);
endinterface

interface b2b_dig_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [3:0]  digest_valid_bytes;
    logic        digest_last;
    modport source (output valid, digest_word, digest_valid_bytes, digest_last, input ready);
    modport sink   (input valid, digest_word, digest_valid_bytes, digest_last, output ready);
endinterface

interface b2b_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] digest_bytes;
    modport source (output valid, digest_bytes, input ready);
    modport sink   (input valid, digest_bytes, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/b2b_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module b2b_ram #(
    parameter int Width = 64,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/blake2b_hash_engine_top.sv
// BLAKE2b unkeyed hash engine top level; needs b2b_pkg, b2b_if and b2b_ram.
// Each word is accepted, then packed into the block RAM one byte a cycle, pausing for a
// compression when the block fills, then closed. A compression loads the working state,
// runs 12 rounds of 8 G steps, then folds the result into the chain value. After the
// last word: its bytes, zero padding, the compression, then, while the sink is ready, one
// digest word a cycle. Synchronous active-low reset clears control, loads IV, length 64.
`default_nettype none
module blake2b_hash_engine_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    b2b_msg_if.sink   msg,
    b2b_dig_if.source dig,
    b2b_cfg_if.sink   cfg
);
    import b2b_pkg::*;

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StPack = 3'd1;
    localparam logic [2:0] StInit = 3'd2;
    localparam logic [2:0] StMix  = 3'd3;
    localparam logic [2:0] StFin  = 3'd4;
    localparam logic [2:0] StPad  = 3'd5;
    localparam logic [2:0] StOut  = 3'd6;

    logic [2:0]   r_st;
    logic [6:0]   r_len_cfg, r_len;
    logic         r_busy;
    t_word        r_h [8];
    t_word        r_v [16];
    logic [7:0]   r_fill;
    logic [127:0] r_total;
    logic [63:0]  r_word;
    logic [3:0]   r_cnt;
    logic         r_last, r_final;
    logic [3:0]   r_round;
    logic [2:0]   r_g;
    logic [1:0]   r_ph;
    t_word        r_acc;          // word under assembly in RAM slot
    logic [3:0]   r_oi;

    // message RAM
    logic        ram_we;
    logic [3:0]  ram_wa, ram_ra;
    t_word       ram_wd, ram_rd;
    b2b_ram #(.Width(WordW), .Depth(BlkWords)) u_mblk (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_wa), .i_wdata(ram_wd),
        .i_raddr(ram_ra), .o_rdata(ram_rd)
    );

    assign msg.ready = (r_st == StIdle);
    assign cfg.ready = 1'b1;

    // G step indices
    logic [3:0] ia, ib, ic, id;
    always_comb begin
        if (!r_g[2]) begin
            ia = {2'b00, r_g[1:0]}; ib = ia + 4'd4; ic = ia + 4'd8; id = ia + 4'd12;
        end else begin
            ia = {2'b00, r_g[1:0]};
            ib = {2'b01, r_g[1:0] + 2'd1};
            ic = {2'b10, r_g[1:0] + 2'd2};
            id = {2'b11, r_g[1:0] + 2'd3};
        end
    end
    logic [3:0] rsel;
    assign rsel = (r_round >= 4'd10) ? r_round - 4'd10 : r_round;

    // half-G datapath: phase 1 takes x, phase 3 takes y, straight from the RAM
    t_word a1, dx, d1, c1, bx, b1;
    logic  hi;
    assign hi = r_ph[1];
    always_comb begin
        a1 = r_v[ia] + r_v[ib] + ram_rd;
        dx = r_v[id] ^ a1;
        d1 = hi ? {dx[15:0], dx[63:16]} : {dx[31:0], dx[63:32]};
        c1 = r_v[ic] + d1;
        bx = r_v[ib] ^ c1;
        b1 = hi ? {bx[62:0], bx[63]} : {bx[23:0], bx[63:24]};
    end

    // byte placement of current input byte
    logic [2:0] bpos;
    assign bpos = r_fill[2:0];

    always_comb begin
        ram_we = 1'b0; ram_wa = r_fill[6:3]; ram_wd = r_acc; ram_ra = '0;
        case (r_st)
            StPack: begin
                ram_we = (r_cnt != 4'd0) && !r_fill[7];
                ram_wd = r_acc;
                ram_wd[bpos*8 +: 8] = r_word[7:0];
            end
            StPad: begin
                ram_we = !r_fill[7];
                ram_wa = r_fill[6:3];
                ram_wd = r_acc;
                for (int k = 0; k < 8; k++)
                    if (k[2:0] >= bpos) ram_wd[k*8 +: 8] = 8'h00;
            end
            StMix: ram_ra = sigma(rsel, {r_g, r_ph[1]});
            default: ram_ra = '0;
        endcase
    end

    logic [6:0] cfg_v;
    assign cfg_v = clamp_len(cfg.digest_bytes);
    logic [6:0] rem;
    assign rem = r_len - {1'b0, r_oi[2:0], 3'b000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= StIdle; r_len_cfg <= 7'd64; r_len <= 7'd64; r_busy <= 1'b0;
            r_fill <= '0; r_total <= '0; dig.valid <= 1'b0;
            for (int k = 1; k < 8; k++) r_h[k] <= iv(k[2:0]);
            r_h[0] <= iv(3'd0) ^ ParamXor ^ 64'd64;
        end else begin
            if (cfg.valid) r_len_cfg <= cfg_v;
            case (r_st)
                StIdle: if (msg.valid) begin
                    r_word <= msg.msg_word;
                    r_cnt  <= (msg.byte_count > 4'd8) ? 4'd8 : msg.byte_count;
                    r_last <= msg.last_word;
                    r_st   <= StPack;
                    if (!r_busy) begin
                        r_busy <= 1'b1; r_len <= r_len_cfg; r_fill <= '0; r_total <= '0;
                        r_acc <= '0;
                        for (int k = 1; k < 8; k++) r_h[k] <= iv(k[2:0]);
                        r_h[0] <= iv(3'd0) ^ ParamXor ^ {57'd0, r_len_cfg};
                    end
                end
                StPack: begin
                    if (r_cnt == 4'd0) begin
                        if (r_last) begin
                            r_total <= r_total + {120'd0, r_fill};
                            r_final <= 1'b1;
                            r_st <= (r_fill[7]) ? StInit : StPad;
                        end else r_st <= StIdle;
                    end else if (r_fill[7]) begin
                        r_total <= r_total + 128'd128;
                        r_final <= 1'b0;
                        r_st <= StInit;
                    end else begin
                        if (bpos == 3'd7) r_acc <= '0;
                        else r_acc[bpos*8 +: 8] <= r_word[7:0];
                        r_word <= r_word >> 8;
                        r_cnt <= r_cnt - 4'd1;
                        r_fill <= r_fill + 8'd1;
                    end
                end
                StPad: begin
                    r_acc <= '0;
                    if (r_fill[7]) r_st <= StInit;
                    else r_fill <= {r_fill[7:3] + 5'd1, 3'b000};
                end
                StInit: begin
                    for (int k = 0; k < 8; k++) r_v[k] <= r_h[k];
                    for (int k = 0; k < 4; k++) r_v[k+8] <= iv(k[2:0]);
                    r_v[12] <= iv(3'd4) ^ r_total[63:0];
                    r_v[13] <= iv(3'd5) ^ r_total[127:64];
                    r_v[14] <= r_final ? ~iv(3'd6) : iv(3'd6);
                    r_v[15] <= iv(3'd7);
                    r_round <= '0; r_g <= '0; r_ph <= 2'd0;
                    r_st <= StMix;
                end
                StMix: begin
                    // even phase: RAM read issued; odd phase: data valid, apply half G
                    r_ph <= r_ph + 2'd1;
                    if (r_ph[0]) begin
                        r_v[ia] <= a1;
                        r_v[id] <= d1; r_v[ic] <= c1; r_v[ib] <= b1;
                        if (r_ph == 2'd3) begin
                            r_g <= r_g + 3'd1;
                            if (r_g == 3'd7) begin
                                r_round <= r_round + 4'd1;
                                if (r_round == 4'(Rounds - 1)) r_st <= StFin;
                            end
                        end
                    end
                end
                StFin: begin
                    for (int k = 0; k < 8; k++) r_h[k] <= r_h[k] ^ r_v[k] ^ r_v[k+8];
                    if (r_final) begin
                        r_oi <= '0; r_st <= StOut;
                    end else begin
                        r_fill <= '0; r_acc <= '0; r_st <= StPack;
                    end
                end
                StOut: if (!dig.valid || dig.ready) begin
                    if ({1'b0, r_oi[2:0], 3'b000} < r_len && !r_oi[3]) begin
                        dig.valid <= 1'b1;
                        dig.digest_word <= (rem >= 7'd8) ? r_h[r_oi[2:0]] :
                            r_h[r_oi[2:0]] & ((64'd1 << {rem[2:0], 3'b000}) - 64'd1);
                        dig.digest_valid_bytes <= (rem >= 7'd8) ? 4'd8 : rem[3:0];
                        dig.digest_last <= (rem <= 7'd8);
                        r_oi <= r_oi + 4'd1;
                    end else begin
                        dig.valid <= 1'b0;
                        r_busy <= 1'b0; r_fill <= '0; r_total <= '0;
                        r_st <= StIdle;
                    end
                end
                default: r_st <= StIdle;
            endcase
            if (r_st != StOut && dig.valid && dig.ready) dig.valid <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// File: verif/b2b_digest_checker.sv
// Checker for the BLAKE2b engine: watches the message, digest and length channels,
// predicts each digest word and compares it. Depends on b2b_if.
`timescale 1ns / 100ps
module b2b_digest_checker (
    input  logic     i_clk,
    input  logic     i_rst_n,
    b2b_msg_if       msg,
    b2b_dig_if       dig,
    b2b_cfg_if       cfg,
    output int       o_errors,
    output int       o_pending
);
    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
    } t_digest_word;

    localparam logic [63:0] CHAIN_INIT [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

    logic [3:0] perm_order [10][16] = '{
        '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
        '{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
        '{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
        '{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
        '{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
        '{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
        '{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
        '{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
        '{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
        '{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}};

    logic [63:0]  chain [8];
    logic [63:0]  blk [16];
    logic [63:0]  work [16];
    logic [127:0] byte_sum;
    int unsigned  fill;
    int unsigned  len_reg;
    int unsigned  len_msg;
    bit           in_msg;
    t_digest_word digest_q [$];

    assign o_pending = digest_q.size();

    function automatic logic [63:0] rotr(input logic [63:0] x, input int r);
        return (x >> r) | (x << (64 - r));
    endfunction

    function automatic void mix(input int a, input int b, input int c, input int d,
                                input logic [63:0] x, input logic [63:0] y);
        work[a] = work[a] + work[b] + x;
        work[d] = rotr(work[d] ^ work[a], 32);
        work[c] = work[c] + work[d];
        work[b] = rotr(work[b] ^ work[c], 24);
        work[a] = work[a] + work[b] + y;
        work[d] = rotr(work[d] ^ work[a], 16);
        work[c] = work[c] + work[d];
        work[b] = rotr(work[b] ^ work[c], 63);
    endfunction

    function automatic void compress(input bit fin);
        int s;
        for (int i = 0; i < 8; i++) begin
            work[i] = chain[i];
            work[i+8] = CHAIN_INIT[i];
        end
        work[12] ^= byte_sum[63:0];
        work[13] ^= byte_sum[127:64];
        if (fin) work[14] = ~work[14];
        for (int r = 0; r < 12; r++) begin
            s = r % 10;
            mix(0, 4, 8, 12, blk[perm_order[s][0]], blk[perm_order[s][1]]);
            mix(1, 5, 9, 13, blk[perm_order[s][2]], blk[perm_order[s][3]]);
            mix(2, 6, 10, 14, blk[perm_order[s][4]], blk[perm_order[s][5]]);
            mix(3, 7, 11, 15, blk[perm_order[s][6]], blk[perm_order[s][7]]);
            mix(0, 5, 10, 15, blk[perm_order[s][8]], blk[perm_order[s][9]]);
            mix(1, 6, 11, 12, blk[perm_order[s][10]], blk[perm_order[s][11]]);
            mix(2, 7, 8, 13, blk[perm_order[s][12]], blk[perm_order[s][13]]);
            mix(3, 4, 9, 14, blk[perm_order[s][14]], blk[perm_order[s][15]]);
        end
        for (int i = 0; i < 8; i++) chain[i] ^= work[i] ^ work[i+8];
    endfunction

    function automatic void absorb_word(input logic [63:0] w, input logic [3:0] bc,
                                        input logic lst);
        int unsigned n;
        int unsigned nw;
        int unsigned vb;
        t_digest_word d;
        n = (bc > 8) ? 8 : bc;
        if (!in_msg) begin
            in_msg = 1;
            len_msg = len_reg;
            foreach (chain[i]) chain[i] = CHAIN_INIT[i];
            chain[0] ^= 64'h0101_0000 ^ 64'(len_msg);
            fill = 0;
            byte_sum = '0;
        end
        for (int i = 0; i < n; i++) begin
            if (fill >= 128) begin
                byte_sum += 128;
                compress(0);
                fill = 0;
            end
            blk[fill >> 3][(fill & 7) * 8 +: 8] = w[8*i +: 8];
            fill++;
        end
        if (!lst) return;
        byte_sum += fill;
        for (int i = fill; i < 128; i++) blk[i >> 3][(i & 7) * 8 +: 8] = 8'h00;
        compress(1);
        nw = (len_msg + 7) / 8;
        for (int i = 0; i < nw; i++) begin
            vb = (len_msg - 8 * i > 8) ? 8 : len_msg - 8 * i;
            d.word = chain[i];
            if (vb < 8) d.word &= (64'd1 << (8 * vb)) - 1;
            d.nbytes = 4'(vb);
            d.last = (i + 1 == nw);
            digest_q.push_back(d);
        end
        in_msg = 0;
    endfunction

    initial begin
        o_errors = 0;
        len_reg = 64;
        in_msg = 0;
    end

    always @(posedge i_clk) begin
        t_digest_word exp_w;
        if (i_rst_n) begin
            if (cfg.valid && cfg.ready)
                len_reg = (cfg.digest_bytes == 0) ? 1 :
                          (cfg.digest_bytes > 64) ? 64 : cfg.digest_bytes;
            if (msg.valid && msg.ready)
                absorb_word(msg.msg_word, msg.byte_count, msg.last_word);
            if (dig.valid && dig.ready) begin
                if (digest_q.size() == 0) begin
                    $display("%0t: unexpected digest word %h", $time, dig.digest_word);
                    o_errors++;
                end else begin
                    exp_w = digest_q.pop_front();
                    if (dig.digest_word !== exp_w.word) begin
                        $display("%0t: digest_word expected %h actual %h",
                                 $time, exp_w.word, dig.digest_word);
                        o_errors++;
                    end
                    if (dig.digest_valid_bytes !== exp_w.nbytes) begin
                        $display("%0t: digest_valid_bytes expected %0d actual %0d",
                                 $time, exp_w.nbytes, dig.digest_valid_bytes);
                        o_errors++;
                    end
                    if (dig.digest_last !== exp_w.last) begin
                        $display("%0t: digest_last expected %0d actual %0d",
                                 $time, exp_w.last, dig.digest_last);
                        o_errors++;
                    end
                end
            end
        end
    end
endmodule

// File: verif/blake2b_hash_engine_top_tb.sv
// Testbench top for the BLAKE2b engine: clock, reset, message and length stimulus,
// digest sink with stalls, verdict. Depends on b2b_if, the engine and b2b_digest_checker.
`timescale 1ns / 100ps
module blake2b_hash_engine_top_tb;
    logic i_clk = 0;
    logic i_rst_n = 0;
    int   errors;
    int   pending;
    int   items_sent;
    bit   calm;
    bit   hold_req;

    b2b_msg_if msg_ch ();
    b2b_dig_if dig_ch ();
    b2b_cfg_if cfg_ch ();

    blake2b_hash_engine_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .msg     (msg_ch),
        .dig     (dig_ch),
        .cfg     (cfg_ch)
    );

    b2b_digest_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .msg       (msg_ch),
        .dig       (dig_ch),
        .cfg       (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #30_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        msg_ch.valid = 0;
        msg_ch.msg_word = '0;
        msg_ch.byte_count = '0;
        msg_ch.last_word = 0;
        cfg_ch.valid = 0;
        cfg_ch.digest_bytes = '0;
        dig_ch.ready = 0;
    end

    // digest sink
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                dig_ch.ready <= 0;
                repeat (3000) @(posedge i_clk);
            end
            dig_ch.ready <= calm || $urandom_range(99) >= 17;
        end
    end

    task automatic send_word(input logic [63:0] w, input logic [3:0] bc, input logic lst);
        if (!calm && $urandom_range(99) < 17) begin
            msg_ch.valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        msg_ch.valid <= 1;
        msg_ch.msg_word <= w;
        msg_ch.byte_count <= bc;
        msg_ch.last_word <= lst;
        do @(posedge i_clk); while (!msg_ch.ready);
        items_sent++;
    endtask

    task automatic wait_drained();
        msg_ch.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_len(input logic [6:0] len);
        wait_drained();
        cfg_ch.valid <= 1;
        cfg_ch.digest_bytes <= len;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 0;
    endtask

    initial begin
        int nw;
        bit noisy;
        items_sent = 0;
        calm = 0;
        hold_req = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // empty message, then one byte
        write_len(7'd64);
        send_word(64'h0, 4'd0, 1);
        send_word(64'hffff_ffff_ffff_ffff, 4'd1, 1);
        // exactly one full block, shortest digest
        write_len(7'd1);
        for (int k = 0; k < 16; k++)
            send_word(k[0] ? 64'hffff_ffff_ffff_ffff : 64'h0, 4'd8, k == 15);
        // zero length clamps up, over-long clamps down
        write_len(7'd0);
        send_word(64'h0123_4567_89ab_cdef, 4'd3, 0);
        send_word(64'hfedc_ba98_7654_3210, 4'd12, 1);
        write_len(7'd127);
        send_word(64'h5555_aaaa_5555_aaaa, 4'd8, 0);
        send_word(64'haaaa_5555_aaaa_5555, 4'd0, 1);

        for (int m = 0; items_sent < 120; m++) begin
            if (m != 4 && $urandom_range(1)) write_len(7'($urandom_range(127)));
            calm = (m >= 5 && m <= 7);
            if (m == 3) begin
                hold_req <= 1;
                @(posedge i_clk);
                hold_req <= 0;
            end
            nw = (m == 3 || m == 4) ? 20 : $urandom_range(20);
            noisy = $urandom_range(9) == 0;
            for (int k = 0; k < nw; k++)
                send_word({$urandom, $urandom},
                          noisy ? 4'($urandom_range(15)) : 4'd8, 0);
            send_word({$urandom, $urandom},
                      $urandom_range(3) == 0 ? 4'($urandom_range(15))
                                             : 4'($urandom_range(8)), 1);
            if (m % 4 == 2) wait_drained();
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
